[rtl/tcpfm_pkg.sv]
// ----------------------------------------------------------------------------
// tcpfm_pkg
// Shared widths, command/status structs and controller states for the
// two-channel period and frequency meter.
// ----------------------------------------------------------------------------
package tcpfm_pkg;

   // capture counter and derived period width (one extra bit for a wrap)
   localparam int unsigned COUNTER_BITS = 16;
   localparam int unsigned PERIOD_BITS  = COUNTER_BITS + 1;

   // tick rate, dividend and quotient width
   localparam int unsigned RATE_BITS = 27;
   localparam int unsigned STEP_BITS = $clog2(RATE_BITS + 1);

   localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(12000000);

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_A,
      ST_WAIT_A,
      ST_START_B,
      ST_WAIT_B,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;  // latch the accepted item, update channel state
      logic div_start;  // start the shared divider
      logic div_sel_b;  // divisor is channel B's period
      logic store_a;    // quotient is channel A's frequency
      logic store_b;    // quotient is channel B's frequency
      logic out_load;   // move the finished result into the output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div_a; // channel A completed a non-zero period
      logic need_div_b; // channel B completed a non-zero period
      logic div_done;   // quotient ready this cycle
      logic out_free;   // output register can take a result this cycle
   } dpath_status_type;

endpackage

[rtl/tcpfm_div.sv]
// ----------------------------------------------------------------------------
// tcpfm_div
// Restoring radix-2 divider: one quotient bit per cycle, RATE_BITS quotient bits.
// ----------------------------------------------------------------------------
module tcpfm_div
   import tcpfm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [RATE_BITS-1:0]   dividend,
   input  logic [PERIOD_BITS-1:0] divisor,
   output logic                   done,
   output logic [RATE_BITS-1:0]   quotient
);

   logic [PERIOD_BITS-1:0] rem_ff, rem_in;
   logic [RATE_BITS-1:0]   quo_ff, quo_in;
   logic [PERIOD_BITS-1:0] dvs_ff, dvs_in;
   logic [STEP_BITS-1:0]   count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [PERIOD_BITS:0]   partial;
   logic [PERIOD_BITS:0]   trial;

   // one subtract-and-shift step
   always_comb begin
      partial  = {rem_ff, quo_ff[RATE_BITS-1]};
      trial    = partial - {1'b0, dvs_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
         count_in = STEP_BITS'(RATE_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[PERIOD_BITS]) begin
            rem_in = trial[PERIOD_BITS-1:0];
            quo_in = {quo_ff[RATE_BITS-2:0], 1'b1};
         end else begin
            // partial stays below the divisor, so it fits
            rem_in = partial[PERIOD_BITS-1:0];
            quo_in = {quo_ff[RATE_BITS-2:0], 1'b0};
         end
         count_in = count_ff - STEP_BITS'(1);
         if (count_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/tcpfm_dpath.sv]
// ----------------------------------------------------------------------------
// tcpfm_dpath
// Channel state, period calculation, tick rate register, shared divider and
// output register.
// ----------------------------------------------------------------------------
module tcpfm_dpath
   import tcpfm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dpath_status_type        status,
   input  logic                    csr_wr_en,
   input  logic [RATE_BITS-1:0]    csr_wr_data,
   input  logic                    counter_overflow,
   input  logic                    capture_a_valid,
   input  logic [COUNTER_BITS-1:0] capture_a_value,
   input  logic                    capture_b_valid,
   input  logic [COUNTER_BITS-1:0] capture_b_value,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic                    freq_a_valid,
   output logic [RATE_BITS-1:0]    freq_a,
   output logic                    freq_b_valid,
   output logic [RATE_BITS-1:0]    freq_b,
   output logic                    zero_period_error
);

   localparam logic [PERIOD_BITS-1:0] FULL_SPAN = {1'b1, {COUNTER_BITS{1'b0}}};

   // channel state
   logic                    armed_a_ff, armed_a_in, armed_b_ff, armed_b_in;
   logic                    wrap_a_ff, wrap_a_in, wrap_b_ff, wrap_b_in;
   logic [COUNTER_BITS-1:0] start_a_ff, start_a_in, start_b_ff, start_b_in;
   // per-item working values
   logic [PERIOD_BITS-1:0]  period_a_ff, period_a_in, period_b_ff, period_b_in;
   logic                    done_a_ff, done_a_in, done_b_ff, done_b_in;
   logic [RATE_BITS-1:0]    fa_ff, fa_in, fb_ff, fb_in;
   logic [RATE_BITS-1:0]    rate_ff, rate_in;
   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    o_va_ff, o_va_in, o_vb_ff, o_vb_in, o_err_ff, o_err_in;
   logic [RATE_BITS-1:0]    o_fa_ff, o_fa_in, o_fb_ff, o_fb_in;

   logic                    eff_wrap_a, eff_wrap_b;
   logic [PERIOD_BITS-1:0]  span_a, span_b;
   logic                    div_done;
   logic [RATE_BITS-1:0]    quotient;
   logic                    zero_a, zero_b;

   // a wrap counts only for a channel already armed
   assign eff_wrap_a = wrap_a_ff | (counter_overflow & armed_a_ff);
   assign eff_wrap_b = wrap_b_ff | (counter_overflow & armed_b_ff);

   // period: full span minus start plus end after a wrap, else end minus start
   assign span_a = eff_wrap_a
      ? FULL_SPAN - {1'b0, start_a_ff} + {1'b0, capture_a_value}
      : {1'b0, capture_a_value - start_a_ff};
   assign span_b = eff_wrap_b
      ? FULL_SPAN - {1'b0, start_b_ff} + {1'b0, capture_b_value}
      : {1'b0, capture_b_value - start_b_ff};

   assign zero_a = (period_a_ff == '0);
   assign zero_b = (period_b_ff == '0);

   // item intake and channel update
   always_comb begin
      armed_a_in  = armed_a_ff;
      armed_b_in  = armed_b_ff;
      wrap_a_in   = wrap_a_ff;
      wrap_b_in   = wrap_b_ff;
      start_a_in  = start_a_ff;
      start_b_in  = start_b_ff;
      period_a_in = period_a_ff;
      period_b_in = period_b_ff;
      done_a_in   = done_a_ff;
      done_b_in   = done_b_ff;
      if (cmd.load_item) begin
         wrap_a_in = eff_wrap_a;
         wrap_b_in = eff_wrap_b;
         done_a_in = 1'b0;
         done_b_in = 1'b0;
         if (capture_a_valid) begin
            if (armed_a_ff) begin
               period_a_in = span_a;
               done_a_in   = 1'b1;
               armed_a_in  = 1'b0;
               wrap_a_in   = 1'b0;
            end else begin
               armed_a_in = 1'b1;
               start_a_in = capture_a_value;
            end
         end
         if (capture_b_valid) begin
            if (armed_b_ff) begin
               period_b_in = span_b;
               done_b_in   = 1'b1;
               armed_b_in  = 1'b0;
               wrap_b_in   = 1'b0;
            end else begin
               armed_b_in = 1'b1;
               start_b_in = capture_b_value;
            end
         end
      end
   end

   // frequency results; a zero period leaves 0
   always_comb begin
      fa_in = fa_ff;
      fb_in = fb_ff;
      if (cmd.load_item) begin
         fa_in = '0;
         fb_in = '0;
      end
      if (cmd.store_a) fa_in = quotient;
      if (cmd.store_b) fb_in = quotient;
   end

   // tick rate register
   assign rate_in = csr_wr_en ? csr_wr_data : rate_ff;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      o_va_in      = o_va_ff;
      o_vb_in      = o_vb_ff;
      o_fa_in      = o_fa_ff;
      o_fb_in      = o_fb_ff;
      o_err_in     = o_err_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         o_va_in      = done_a_ff;
         o_vb_in      = done_b_ff;
         o_fa_in      = fa_ff;
         o_fb_in      = fb_ff;
         o_err_in     = (done_a_ff & zero_a) | (done_b_ff & zero_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_a_ff   <= 1'b0;
         armed_b_ff   <= 1'b0;
         wrap_a_ff    <= 1'b0;
         wrap_b_ff    <= 1'b0;
         start_a_ff   <= '0;
         start_b_ff   <= '0;
         done_a_ff    <= 1'b0;
         done_b_ff    <= 1'b0;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         armed_a_ff   <= armed_a_in;
         armed_b_ff   <= armed_b_in;
         wrap_a_ff    <= wrap_a_in;
         wrap_b_ff    <= wrap_b_in;
         start_a_ff   <= start_a_in;
         start_b_ff   <= start_b_in;
         done_a_ff    <= done_a_in;
         done_b_ff    <= done_b_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      period_a_ff <= period_a_in;
      period_b_ff <= period_b_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      o_va_ff     <= o_va_in;
      o_vb_ff     <= o_vb_in;
      o_fa_ff     <= o_fa_in;
      o_fb_ff     <= o_fb_in;
      o_err_ff    <= o_err_in;
   end

   // shared divider
   tcpfm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rate_ff),
      .divisor  (cmd.div_sel_b ? period_b_ff : period_a_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // status to controller
   assign status.need_div_a = done_a_ff & ~zero_a;
   assign status.need_div_b = done_b_ff & ~zero_b;
   assign status.div_done   = div_done;
   assign status.out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign freq_a_valid      = o_va_ff;
   assign freq_a            = o_fa_ff;
   assign freq_b_valid      = o_vb_ff;
   assign freq_b            = o_fb_ff;
   assign zero_period_error = o_err_ff;

endmodule

[rtl/tcpfm_ctrl.sv]
// ----------------------------------------------------------------------------
// tcpfm_ctrl
// Sequencer: takes an item, runs the divider for each channel with a completed
// non-zero period, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tcpfm_ctrl
   import tcpfm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dpath_status_type status,
   output ctrl_cmd_type     cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_START_A;
         ST_START_A: state_in = status.need_div_a ? ST_WAIT_A : ST_START_B;
         ST_WAIT_A:  if (status.div_done) state_in = ST_START_B;
         ST_START_B: state_in = status.need_div_b ? ST_WAIT_B : ST_FINISH;
         ST_WAIT_B:  if (status.div_done) state_in = ST_FINISH;
         ST_FINISH:  if (status.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.load_item = req_valid;
         end
         ST_START_A: cmd.div_start = status.need_div_a;
         ST_WAIT_A:  cmd.store_a   = status.div_done;
         ST_START_B: begin
            cmd.div_start = status.need_div_b;
            cmd.div_sel_b = 1'b1;
         end
         ST_WAIT_B: begin
            cmd.div_sel_b = 1'b1;
            cmd.store_b   = status.div_done;
         end
         ST_FINISH: cmd.out_load = status.out_free;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/two_channel_period_frequency_meter_unit.sv]
// ----------------------------------------------------------------------------
// two_channel_period_frequency_meter_unit
// Two-channel input-capture frequency meter: period from a free-running
// counter, frequency as tick rate divided by period.
//
//   Channel  Ports                     Handshake        Payload
//   request  req_*                     valid / stall    overflow, two captures
//   result   rsp_*                     valid / stall    two frequencies, error
//   config   csr_wr_en, csr_wr_data    write enable     tick rate (27 bits)
//
// An item passes through ST_START_A, ST_START_B and ST_FINISH, and waits in
// ST_WAIT_A or ST_WAIT_B for each channel whose completed period is non-zero,
// while the shared restoring divider works out one quotient bit per cycle.
// Reset is synchronous: both channels disarmed, tick rate 12000000.
// The result sits in an output register; a stalled result holds back only
// the hand-off of the next finished item, not its intake.
// ----------------------------------------------------------------------------
module two_channel_period_frequency_meter_unit
   import tcpfm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [RATE_BITS-1:0]    csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_counter_overflow,
   input  logic                    req_capture_a_valid,
   input  logic [COUNTER_BITS-1:0] req_capture_a_value,
   input  logic                    req_capture_b_valid,
   input  logic [COUNTER_BITS-1:0] req_capture_b_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_freq_a_valid,
   output logic [RATE_BITS-1:0]    rsp_freq_a,
   output logic                    rsp_freq_b_valid,
   output logic [RATE_BITS-1:0]    rsp_freq_b,
   output logic                    rsp_zero_period_error
);

   ctrl_cmd_type     cmd;
   dpath_status_type status;

   // sequencer
   tcpfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   tcpfm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .counter_overflow  (req_counter_overflow),
      .capture_a_valid   (req_capture_a_valid),
      .capture_a_value   (req_capture_a_value),
      .capture_b_valid   (req_capture_b_valid),
      .capture_b_value   (req_capture_b_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .freq_a_valid      (rsp_freq_a_valid),
      .freq_a            (rsp_freq_a),
      .freq_b_valid      (rsp_freq_b_valid),
      .freq_b            (rsp_freq_b),
      .zero_period_error (rsp_zero_period_error)
   );

   // an accepted item closes intake until its result moves into the output register
   a_intake_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("intake stayed open after an item was accepted");

   // the error flag needs a completed period on some channel
   a_err_has_period: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_period_error) |-> (rsp_freq_a_valid || rsp_freq_b_valid))
      else $error("zero period flagged without a completed period");

   // one quotient goes to one channel only
   a_single_store: assert property (@(posedge clock) disable iff (reset)
      !(cmd.store_a && cmd.store_b))
      else $error("quotient stored to both channels");

   // an idle channel A reports zero
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_freq_a_valid) |-> (rsp_freq_a == '0))
      else $error("channel A frequency non-zero without a period");

endmodule

[dv/two_channel_period_frequency_meter_unit_tb.sv]
// ----------------------------------------------------------------------------
// two_channel_period_frequency_meter_unit_tb
// Self-checking bench for the two-channel period and frequency meter. A
// clocked driver feeds capture items from a queue and a clocked monitor
// compares every result item, field by field, with the frequencies worked
// out by a local model of both channels. The tick rate is changed between
// phases, including zero and full scale. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module two_channel_period_frequency_meter_unit_tb
   import tcpfm_pkg::*;
();

   typedef struct packed {
      logic                    wrap;
      logic                    a_hit;
      logic [COUNTER_BITS-1:0] a_stamp;
      logic                    b_hit;
      logic [COUNTER_BITS-1:0] b_stamp;
   } capture_item_type;

   typedef struct packed {
      logic                 a_valid;
      logic [RATE_BITS-1:0] a_freq;
      logic                 b_valid;
      logic [RATE_BITS-1:0] b_freq;
      logic                 zero_err;
   } freq_result_type;

   typedef struct packed {
      logic                    armed;
      logic [COUNTER_BITS-1:0] start;
      logic                    wrapped;
   } chan_track_type;

   localparam int unsigned MAX_WAIT     = 13;
   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned NUM_PHASES   = 7;
   localparam int unsigned DRAIN_CYCLES = 80;

   // DUT inputs, all known from time zero
   logic                    clock                = 1'b0;
   logic                    reset                = 1'b1;
   logic                    csr_wr_en            = 1'b0;
   logic [RATE_BITS-1:0]    csr_wr_data          = '0;
   logic                    req_valid            = 1'b0;
   logic                    req_counter_overflow = 1'b0;
   logic                    req_capture_a_valid  = 1'b0;
   logic [COUNTER_BITS-1:0] req_capture_a_value  = '0;
   logic                    req_capture_b_valid  = 1'b0;
   logic [COUNTER_BITS-1:0] req_capture_b_value  = '0;
   logic                    rsp_stall            = 1'b0;

   // DUT outputs
   logic                    req_stall;
   logic                    rsp_valid;
   logic                    rsp_freq_a_valid;
   logic [RATE_BITS-1:0]    rsp_freq_a;
   logic                    rsp_freq_b_valid;
   logic [RATE_BITS-1:0]    rsp_freq_b;
   logic                    rsp_zero_period_error;

   // model state
   logic [RATE_BITS-1:0] tick_rate_shadow = RATE_RESET;
   chan_track_type       chan_a_track     = '0;
   chan_track_type       chan_b_track     = '0;

   capture_item_type capture_queue[$];
   freq_result_type  expected_freqs[$];
   capture_item_type cur_item       = '0;
   logic             presenting     = 1'b0;
   logic             capture_taken  = 1'b0;
   logic             result_taken   = 1'b0;
   logic             send_burst     = 1'b0;
   logic             recv_burst     = 1'b0;
   int               send_wait      = 0;
   int               recv_wait      = 0;
   int               mismatch_count = 0;

   two_channel_period_frequency_meter_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_counter_overflow  (req_counter_overflow),
      .req_capture_a_valid   (req_capture_a_valid),
      .req_capture_a_value   (req_capture_a_value),
      .req_capture_b_valid   (req_capture_b_valid),
      .req_capture_b_value   (req_capture_b_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_freq_a_valid      (rsp_freq_a_valid),
      .rsp_freq_a            (rsp_freq_a),
      .rsp_freq_b_valid      (rsp_freq_b_valid),
      .rsp_freq_b            (rsp_freq_b),
      .rsp_zero_period_error (rsp_zero_period_error)
   );

   // 10 unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one edge on a channel: arm it, or close the period and divide
   task automatic capture_edge(inout chan_track_type ch,
                               input logic [COUNTER_BITS-1:0] stamp,
                               output logic done, output logic [RATE_BITS-1:0] freq,
                               output logic zero);
      logic [COUNTER_BITS-1:0] span;
      logic [PERIOD_BITS-1:0]  period;
      done = 1'b0;
      freq = '0;
      zero = 1'b0;
      if (!ch.armed) begin
         ch.armed = 1'b1;
         ch.start = stamp;
      end else begin
         // a wrap while armed adds one full counter span, however many came
         span = stamp - ch.start;
         if (ch.wrapped)
            period = PERIOD_BITS'(2 ** COUNTER_BITS) - PERIOD_BITS'(ch.start)
                     + PERIOD_BITS'(stamp);
         else
            period = PERIOD_BITS'(span);
         ch.armed   = 1'b0;
         ch.wrapped = 1'b0;
         done       = 1'b1;
         zero       = (period == '0);
         freq       = zero ? '0 : RATE_BITS'(tick_rate_shadow / period);
      end
   endtask

   // expected result item for one accepted capture item
   task automatic predict_frequencies(input capture_item_type it,
                                      output freq_result_type res);
      logic                 va, vb, za, zb;
      logic [RATE_BITS-1:0] fa, fb;
      va = 1'b0; vb = 1'b0; za = 1'b0; zb = 1'b0;
      fa = '0;   fb = '0;
      // wrap lands before the captures; idle channels ignore it
      if (it.wrap) begin
         if (chan_a_track.armed)
            chan_a_track.wrapped = 1'b1;
         if (chan_b_track.armed)
            chan_b_track.wrapped = 1'b1;
      end
      if (it.a_hit)
         capture_edge(chan_a_track, it.a_stamp, va, fa, za);
      if (it.b_hit)
         capture_edge(chan_b_track, it.b_stamp, vb, fb, zb);
      res.a_valid  = va;
      res.a_freq   = fa;
      res.b_valid  = vb;
      res.b_freq   = fb;
      res.zero_err = (va && za) || (vb && zb);
   endtask

   task automatic check_field(input string name, input logic [RATE_BITS-1:0] want,
                              input logic [RATE_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic queue_capture(input logic wrap, input logic a_hit,
                                input logic [COUNTER_BITS-1:0] a_stamp, input logic b_hit,
                                input logic [COUNTER_BITS-1:0] b_stamp);
      capture_item_type it;
      it.wrap    = wrap;
      it.a_hit   = a_hit;
      it.a_stamp = a_stamp;
      it.b_hit   = b_hit;
      it.b_stamp = b_stamp;
      capture_queue.push_back(it);
   endtask

   // timestamps biased towards the ends of the counter and repeated edges
   function automatic logic [COUNTER_BITS-1:0] pick_stamp(input logic [COUNTER_BITS-1:0] prev);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return prev;
         4:       return prev + COUNTER_BITS'($urandom_range(1, 16));
         default: return COUNTER_BITS'($urandom);
      endcase
   endfunction

   // wait until every queued item has gone in and its result come back
   task automatic wait_for_drain();
      while (capture_queue.size() != 0 || presenting || expected_freqs.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_tick_rate(input logic [RATE_BITS-1:0] rate);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rate;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // input side: note accepted items and predict their results
   always @(posedge clock) begin : capture_accept
      freq_result_type res;
      capture_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_frequencies(cur_item, res);
         expected_freqs.push_back(res);
      end
      if (!reset && csr_wr_en)
         tick_rate_shadow = csr_wr_data;
   end

   // input side: present items from the queue with random gaps
   always @(negedge clock) begin : capture_driver
      if (!reset) begin
         if (capture_taken) begin
            presenting = 1'b0;
            if ($urandom_range(0, 31) == 0)
               send_burst = !send_burst;
            send_wait = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (!presenting) begin
            if (send_wait > 0)
               send_wait--;
            else if (capture_queue.size() != 0) begin
               cur_item   = capture_queue.pop_front();
               presenting = 1'b1;
            end
         end
         req_valid            <= presenting;
         req_counter_overflow <= cur_item.wrap;
         req_capture_a_valid  <= cur_item.a_hit;
         req_capture_a_value  <= cur_item.a_stamp;
         req_capture_b_valid  <= cur_item.b_hit;
         req_capture_b_value  <= cur_item.b_stamp;
      end
   end

   // result side: random stall before each item
   always @(negedge clock) begin : result_stall
      if (result_taken) begin
         if ($urandom_range(0, 31) == 0)
            recv_burst = !recv_burst;
         recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (recv_wait > 0) begin
         recv_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result side: compare against the oldest prediction
   always @(posedge clock) begin : result_check
      freq_result_type want;
      result_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_freqs.size() == 0) begin
            $display("%0t: unexpected result, expected none, got a %0d/%0d b %0d/%0d err %0d",
                     $time, rsp_freq_a_valid, rsp_freq_a, rsp_freq_b_valid, rsp_freq_b,
                     rsp_zero_period_error);
            mismatch_count++;
         end else begin
            want = expected_freqs.pop_front();
            check_field("freq_a_valid", RATE_BITS'(want.a_valid), RATE_BITS'(rsp_freq_a_valid));
            check_field("freq_a", want.a_freq, rsp_freq_a);
            check_field("freq_b_valid", RATE_BITS'(want.b_valid), RATE_BITS'(rsp_freq_b_valid));
            check_field("freq_b", want.b_freq, rsp_freq_b);
            check_field("zero_period_error", RATE_BITS'(want.zero_err),
                        RATE_BITS'(rsp_zero_period_error));
         end
      end
   end

   // stimulus: directed edges at the reset tick rate, then random phases
   initial begin : stimulus
      logic [COUNTER_BITS-1:0] last_a;
      logic [COUNTER_BITS-1:0] last_b;
      logic [RATE_BITS-1:0]    rate;
      logic                    a_hit;
      logic                    b_hit;
      int unsigned             phase;
      int unsigned             n;
      last_a = '0;
      last_b = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wrap on idle channel ignored, and not counted when only arming
      queue_capture(1'b1, 1'b1, 16'd100, 1'b0, 16'h0000);
      // same stamp again: zero period on A
      queue_capture(1'b0, 1'b1, 16'd100, 1'b0, 16'h0000);
      // end below start with no wrap: difference wraps to 1
      queue_capture(1'b0, 1'b0, 16'h0000, 1'b1, 16'hFFFF);
      queue_capture(1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000);
      // two wraps count once; shortest and longest wrapped periods
      queue_capture(1'b0, 1'b1, 16'hFFFF, 1'b1, 16'h0000);
      queue_capture(1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000);
      queue_capture(1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000);
      queue_capture(1'b0, 1'b1, 16'h0000, 1'b1, 16'hFFFF);
      // wrap in the same item as the closing edge: full span on both
      queue_capture(1'b0, 1'b1, 16'h0000, 1'b1, 16'd5);
      queue_capture(1'b1, 1'b1, 16'h0000, 1'b1, 16'd5);
      // both channels zero at once
      queue_capture(1'b0, 1'b1, 16'd1234, 1'b1, 16'd1234);
      queue_capture(1'b0, 1'b1, 16'd1234, 1'b1, 16'd1234);
      // longest plain period on A, exact counter span on B
      queue_capture(1'b0, 1'b1, 16'h0000, 1'b1, 16'd7);
      queue_capture(1'b0, 1'b1, 16'hFFFF, 1'b0, 16'h0000);
      queue_capture(1'b1, 1'b0, 16'h0000, 1'b1, 16'd7);
      // empty item
      queue_capture(1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000);
      // every flag set while arming, alternating bit patterns
      queue_capture(1'b1, 1'b1, 16'hAAAA, 1'b1, 16'h5555);
      queue_capture(1'b0, 1'b1, 16'h5555, 1'b1, 16'hAAAA);
      // one channel zero, the other not: error with a live frequency
      queue_capture(1'b0, 1'b1, 16'd10, 1'b1, 16'd20);
      queue_capture(1'b0, 1'b1, 16'd10, 1'b1, 16'd30);
      wait_for_drain();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       rate = RATE_BITS'(100000000);
            1:       rate = RATE_BITS'(1);
            2:       rate = '0;
            3:       rate = '1;
            6:       rate = RATE_RESET;
            default: rate = RATE_BITS'($urandom_range(1, 100000000));
         endcase
         write_tick_rate(rate);
         for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
            a_hit = 1'($urandom_range(0, 1));
            b_hit = 1'($urandom_range(0, 1));
            if (a_hit)
               last_a = pick_stamp(last_a);
            else
               last_a = last_a ^ COUNTER_BITS'($urandom);
            if (b_hit)
               last_b = pick_stamp(last_b);
            else
               last_b = last_b ^ COUNTER_BITS'($urandom);
            queue_capture($urandom_range(0, 4) == 0, a_hit, last_a, b_hit, last_b);
         end
         wait_for_drain();
      end

      // let any stray result show itself
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_freqs.size() != 0) begin
         $display("%0t: results missing, expected 0 outstanding, got %0d",
                  $time, expected_freqs.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
